// ----- hw/rtl/kthmh_pkg.sv -----
// kthmh_pkg: shared types and constants for the k-th largest min-heap tracker.
// Used by the top level, kthmh_cfg and kthmh_seq; has no dependencies of its own.
package kthmh_pkg;

    localparam int MAX_KEEP    = 1023;
    localparam int STORE_DEPTH = MAX_KEEP + 1;
    localparam int DATA_W      = 32;
    localparam int KEEP_W      = 10;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_KEEP_COUNT = 2'd0;
    localparam logic [KEEP_W-1:0]     KEEP_RESET     = 10'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     preload;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] kth_value;
        logic                     full_res;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_CHECK,
        ST_DROP_RD,
        ST_DN_RD_L,
        ST_DN_RD_R,
        ST_DN_CMP,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/kth_largest_min_heap_top.sv -----
// Flow: accept the word, sift it up one level at a time, then check the count against k;
// while more than k entries are held, move the last entry to the root and sift it down,
// then check again; the result goes out last unless the word was a preload.
// One word at a time, paced by the single RAM read port and the shared comparator.
// Reset: heap empty, keep_count = 1, no word pending; heap RAM contents are not cleared.
// Top level: ties kthmh_cfg, kthmh_seq and kthmh_ram together; uses kthmh_pkg.
module kth_largest_min_heap_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kthmh_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [kthmh_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [kthmh_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  kthmh_pkg::in_word_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output kthmh_pkg::out_word_t              out_data
);

    logic [kthmh_pkg::KEEP_W-1:0] keep;
    logic                         ram_we;
    logic [kthmh_pkg::ADDR_W-1:0] ram_waddr;
    logic [kthmh_pkg::DATA_W-1:0] ram_wdata;
    logic [kthmh_pkg::ADDR_W-1:0] ram_raddr;
    logic [kthmh_pkg::DATA_W-1:0] ram_rdata;

    kthmh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keep    (keep)
    );

    kthmh_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .keep      (keep),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    kthmh_ram #(
        .WIDTH (kthmh_pkg::DATA_W),
        .DEPTH (kthmh_pkg::STORE_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- hw/rtl/kthmh_ram.sv -----
// kthmh_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
module kthmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/kthmh_cfg.sv -----
// kthmh_cfg: APB-style register port holding keep_count (k).
// Depends on kthmh_pkg; supplies the effective k (zero maps to one).
module kthmh_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kthmh_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [kthmh_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [kthmh_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [kthmh_pkg::KEEP_W-1:0]       keep
);

    logic [kthmh_pkg::KEEP_W-1:0] keep_count_reg;
    logic [kthmh_pkg::KEEP_W-1:0] keep_count_next;

    // single register: every write lands in keep_count
    always_comb
    begin
        keep_count_next = keep_count_reg;
        if (psel && penable && pwrite)
        begin
            keep_count_next = pwdata[kthmh_pkg::KEEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= kthmh_pkg::KEEP_RESET;
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == kthmh_pkg::REG_KEEP_COUNT)
                  ? {{(kthmh_pkg::CFG_DATA_W - kthmh_pkg::KEEP_W){1'b0}}, keep_count_reg}
                  : '0;

    assign keep = (keep_count_reg == '0) ? {{(kthmh_pkg::KEEP_W - 1){1'b0}}, 1'b1}
                                         : keep_count_reg;

endmodule

// ----- hw/rtl/kthmh_seq.sv -----
// kthmh_seq: heap sequencer; walks sift-up and sift-down one level at a time
// through a single signed comparator and the heap RAM. Depends on kthmh_pkg.
module kthmh_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [kthmh_pkg::KEEP_W-1:0]      keep,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  kthmh_pkg::in_word_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output kthmh_pkg::out_word_t              out_data,
    output logic                              ram_we,
    output logic [kthmh_pkg::ADDR_W-1:0]      ram_waddr,
    output logic [kthmh_pkg::DATA_W-1:0]      ram_wdata,
    output logic [kthmh_pkg::ADDR_W-1:0]      ram_raddr,
    input  logic [kthmh_pkg::DATA_W-1:0]      ram_rdata
);

    kthmh_pkg::state_t                   state_reg, state_next;
    logic [kthmh_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [kthmh_pkg::ADDR_W-1:0]        hole_reg, hole_next;
    logic [kthmh_pkg::ADDR_W-1:0]        child_reg, child_next;
    logic signed [kthmh_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [kthmh_pkg::DATA_W-1:0] best_reg, best_next;
    logic                                moved_reg, moved_next;
    logic                                have_r_reg, have_r_next;
    logic                                pre_reg, pre_next;
    logic                                out_valid_reg, out_valid_next;
    kthmh_pkg::out_word_t                out_data_reg, out_data_next;
    logic signed [kthmh_pkg::DATA_W-1:0] root_reg;

    logic signed [kthmh_pkg::DATA_W-1:0] cmp_a, cmp_b;
    logic                                cmp_lt;
    logic [kthmh_pkg::ADDR_W-1:0]        parent;
    logic [kthmh_pkg::COUNT_W-1:0]       left_idx, right_idx, keep_ext;
    logic [kthmh_pkg::COUNT_W-1:0]       count_dec;

    // the one shared comparator
    assign cmp_lt = cmp_a < cmp_b;

    assign parent    = (hole_reg - 1'b1) >> 1;
    assign left_idx  = {hole_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign keep_ext  = {1'b0, keep};
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hole_next      = hole_reg;
        child_next     = child_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        moved_next     = moved_reg;
        have_r_next    = have_r_reg;
        pre_next       = pre_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = hole_reg;
        ram_wdata      = val_reg;
        ram_raddr      = '0;
        cmp_a          = val_reg;
        cmp_b          = $signed(ram_rdata);
        in_stall       = 1'b1;

        unique case (state_reg)
            kthmh_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    // append at the end, count stays within the store
                    val_next   = in_data.value;
                    pre_next   = in_data.preload;
                    hole_next  = count_reg[kthmh_pkg::ADDR_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = kthmh_pkg::ST_UP_RD;
                end
            end
            kthmh_pkg::ST_UP_RD:
            begin
                if (hole_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = kthmh_pkg::ST_CHECK;
                end
                else
                begin
                    ram_raddr  = parent;
                    state_next = kthmh_pkg::ST_UP_CMP;
                end
            end
            kthmh_pkg::ST_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = $signed(ram_rdata);
                ram_we = 1'b1;
                if (cmp_lt)
                begin
                    // parent moves down into the hole
                    ram_wdata  = ram_rdata;
                    hole_next  = parent;
                    state_next = kthmh_pkg::ST_UP_RD;
                end
                else
                begin
                    state_next = kthmh_pkg::ST_CHECK;
                end
            end
            kthmh_pkg::ST_CHECK:
            begin
                if (count_reg > keep_ext)
                begin
                    count_next = count_dec;
                    ram_raddr  = count_dec[kthmh_pkg::ADDR_W-1:0];
                    hole_next  = '0;
                    state_next = kthmh_pkg::ST_DROP_RD;
                end
                else
                begin
                    state_next = kthmh_pkg::ST_OUT;
                end
            end
            kthmh_pkg::ST_DROP_RD:
            begin
                // last entry becomes the value sifted down from the root
                val_next   = $signed(ram_rdata);
                state_next = kthmh_pkg::ST_DN_RD_L;
            end
            kthmh_pkg::ST_DN_RD_L:
            begin
                if (left_idx < count_reg)
                begin
                    ram_raddr  = left_idx[kthmh_pkg::ADDR_W-1:0];
                    state_next = kthmh_pkg::ST_DN_RD_R;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = kthmh_pkg::ST_CHECK;
                end
            end
            kthmh_pkg::ST_DN_RD_R:
            begin
                // left child data is here; compare it against the moving value
                cmp_a = $signed(ram_rdata);
                cmp_b = val_reg;
                if (cmp_lt)
                begin
                    best_next  = $signed(ram_rdata);
                    child_next = left_idx[kthmh_pkg::ADDR_W-1:0];
                    moved_next = 1'b1;
                end
                else
                begin
                    best_next  = val_reg;
                    moved_next = 1'b0;
                end
                have_r_next = right_idx < count_reg;
                ram_raddr   = right_idx[kthmh_pkg::ADDR_W-1:0];
                state_next  = kthmh_pkg::ST_DN_CMP;
            end
            kthmh_pkg::ST_DN_CMP:
            begin
                cmp_a  = $signed(ram_rdata);
                cmp_b  = best_reg;
                ram_we = 1'b1;
                if (have_r_reg && cmp_lt)
                begin
                    ram_wdata  = ram_rdata;
                    hole_next  = right_idx[kthmh_pkg::ADDR_W-1:0];
                    state_next = kthmh_pkg::ST_DN_RD_L;
                end
                else if (moved_reg)
                begin
                    ram_wdata  = best_reg;
                    hole_next  = child_reg;
                    state_next = kthmh_pkg::ST_DN_RD_L;
                end
                else
                begin
                    state_next = kthmh_pkg::ST_CHECK;
                end
            end
            kthmh_pkg::ST_OUT:
            begin
                if (pre_reg)
                begin
                    state_next = kthmh_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.kth_value = root_reg;
                    out_data_next.full_res  = (count_reg == keep_ext);
                    state_next              = kthmh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kthmh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kthmh_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        child_reg    <= child_next;
        val_reg      <= val_next;
        best_reg     <= best_next;
        moved_reg    <= moved_next;
        have_r_reg   <= have_r_next;
        pre_reg      <= pre_next;
        out_data_reg <= out_data_next;
        // shadow copy of the root so the result needs no extra RAM read
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= $signed(ram_wdata);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
